>>> rtl/core/tla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line assembler package
// Shared byte codes, result kinds and the structs between the front part,
// the command queue and the readout engine.
// ----------------------------------------------------------------------------
package tla_pkg;

    // Received byte codes with a meaning of their own.
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    // Result kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

    // Widths sized for the largest supported line store (256 characters).
    localparam int LEN_W = 9;
    localparam int IDX_W = 8;

    // Reset value of the line limit register.
    localparam logic [6:0] LIMIT_RESET = 7'd64;

    // One queued job for the readout engine.
    typedef struct packed {
        logic             is_err;
        logic             bank;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // Character write into the line store.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } t_mem_wr;

    // Readout engine releases a bank once its line is fully delivered.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_free;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_LOAD,
        B_WAIT
    } t_back_state;

endpackage

>>> rtl/core/tla_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line assembler front end
// Accepts received bytes, classifies them, writes characters into the
// current store bank and queues line and error jobs.
// ----------------------------------------------------------------------------
module tla_front #(
    parameter int LINE_MAX = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_stall,
    input  logic [7:0]          i_rx_byte,
    input  logic [6:0]          i_line_limit,
    input  logic                i_q_full,
    output logic                o_q_push,
    output tla_pkg::t_cmd       o_q_cmd,
    output tla_pkg::t_mem_wr    o_mem_wr,
    input  tla_pkg::t_bank_free i_bank_free
);

    localparam int CNT_W = $clog2(LINE_MAX + 1);
    localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(LINE_MAX);

    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_wbank, n_wbank;
    logic [1:0]       r_busy, n_busy;

    logic             accept;
    logic             is_cr;
    logic             is_lf;
    logic             printable;
    logic             is_err;
    logic [LIM_W-1:0] limit_ext;
    logic [LIM_W-1:0] active_lim;
    logic [LIM_W-1:0] fill_ext;

    assign o_rx_stall = i_q_full | r_busy[r_wbank];
    assign accept     = i_rx_valid & ~o_rx_stall;

    assign is_cr      = (i_rx_byte == tla_pkg::BYTE_CR);
    assign is_lf      = (i_rx_byte == tla_pkg::BYTE_LF);
    assign printable  = (i_rx_byte >= tla_pkg::PRINT_LO) && (i_rx_byte <= tla_pkg::PRINT_HI);
    assign limit_ext  = LIM_W'(i_line_limit);
    assign active_lim = (limit_ext < MAX_LIM) ? limit_ext : MAX_LIM;
    assign fill_ext   = LIM_W'(r_fill);
    assign is_err     = ~is_cr & ~is_lf & (~printable | (fill_ext >= active_lim));

    always_comb begin
        n_fill          = r_fill;
        n_wbank         = r_wbank;
        n_busy          = r_busy;
        o_q_push        = 1'b0;
        o_q_cmd.is_err  = 1'b0;
        o_q_cmd.bank    = r_wbank;
        o_q_cmd.len     = tla_pkg::LEN_W'(r_fill);
        o_mem_wr.en     = 1'b0;
        o_mem_wr.bank   = r_wbank;
        o_mem_wr.idx    = tla_pkg::IDX_W'(r_fill);
        o_mem_wr.data   = i_rx_byte;

        if (i_bank_free.valid) begin
            n_busy[i_bank_free.bank] = 1'b0;
        end

        if (accept && !is_cr) begin
            if (is_lf) begin
                n_fill = '0;
                // An empty line is dropped without a job.
                if (r_fill != '0) begin
                    o_q_push         = 1'b1;
                    n_busy[r_wbank]  = 1'b1;
                    n_wbank          = ~r_wbank;
                end
            end else if (is_err) begin
                n_fill          = '0;
                o_q_push        = 1'b1;
                o_q_cmd.is_err  = 1'b1;
            end else begin
                o_mem_wr.en = 1'b1;
                n_fill      = r_fill + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_fill  <= n_fill;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

endmodule

>>> rtl/core/tla_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line assembler job queue
// Two-entry queue of jobs between the front end and the readout engine.
// ----------------------------------------------------------------------------
module tla_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tla_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tla_pkg::t_cmd o_cmd
);

    tla_pkg::t_cmd r_slot [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

endmodule

>>> rtl/core/tla_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line assembler readout engine
// Holds the two-bank line store and plays queued jobs out as result beats
// through a registered output stage.
// ----------------------------------------------------------------------------
module tla_back #(
    parameter int LINE_MAX = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tla_pkg::t_mem_wr    i_mem_wr,
    input  logic                i_q_valid,
    input  tla_pkg::t_cmd       i_q_cmd,
    output logic                o_q_pop,
    output tla_pkg::t_bank_free o_bank_free,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic                o_result_kind,
    output logic [7:0]          o_line_char,
    output logic                o_last_of_run
);

    localparam int IDX_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    tla_pkg::t_back_state r_state, n_state;

    logic                      r_bank;
    logic [tla_pkg::LEN_W-1:0] r_len;
    logic [tla_pkg::LEN_W-1:0] r_idx;
    logic                      r_valid;
    logic                      r_kind;
    logic [7:0]                r_char;
    logic                      r_last;

    logic out_take;
    logic do_pop;
    logic load_err;
    logic load_char;
    logic advance;

    assign out_take = r_valid & ~i_res_stall;

    // Line store: one write port from the front end, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[{i_mem_wr.bank, i_mem_wr.idx[IDX_W-1:0]}] <= i_mem_wr.data;
        end
        r_rd_data <= r_mem[{r_bank, r_idx[IDX_W-1:0]}];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tla_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_cmd.is_err ? tla_pkg::B_WAIT : tla_pkg::B_READ;
                end
            end
            tla_pkg::B_READ: n_state = tla_pkg::B_LOAD;
            tla_pkg::B_LOAD: n_state = tla_pkg::B_WAIT;
            tla_pkg::B_WAIT: begin
                if (out_take) begin
                    n_state = r_last ? tla_pkg::B_IDLE : tla_pkg::B_READ;
                end
            end
            default: n_state = tla_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        do_pop            = 1'b0;
        load_err          = 1'b0;
        load_char         = 1'b0;
        advance           = 1'b0;
        o_bank_free.valid = 1'b0;
        o_bank_free.bank  = r_bank;
        unique case (r_state)
            tla_pkg::B_IDLE: begin
                do_pop   = i_q_valid;
                load_err = i_q_valid & i_q_cmd.is_err;
            end
            tla_pkg::B_READ: ;
            tla_pkg::B_LOAD: load_char = 1'b1;
            tla_pkg::B_WAIT: begin
                advance           = out_take & ~r_last;
                o_bank_free.valid = out_take & r_last & (r_kind == tla_pkg::KIND_CHAR);
            end
            default: ;
        endcase
    end

    assign o_q_pop = do_pop;

    always_ff @(posedge i_clk) begin
        if (do_pop && !i_q_cmd.is_err) begin
            r_bank <= i_q_cmd.bank;
            r_len  <= i_q_cmd.len;
        end
        if (do_pop) begin
            r_idx <= '0;
        end else if (advance) begin
            r_idx <= r_idx + tla_pkg::LEN_W'(1);
        end
        if (load_err) begin
            r_kind <= tla_pkg::KIND_ERR;
            r_char <= 8'd0;
            r_last <= 1'b1;
        end else if (load_char) begin
            r_kind <= tla_pkg::KIND_CHAR;
            r_char <= r_rd_data;
            r_last <= ((r_idx + tla_pkg::LEN_W'(1)) == r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tla_pkg::B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_err || load_char) begin
                r_valid <= 1'b1;
            end else if (out_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid   = r_valid;
    assign o_result_kind = r_kind;
    assign o_line_char   = r_char;
    assign o_last_of_run = r_last;

endmodule

>>> rtl/core/text_line_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line assembler
// Gathers received bytes into text lines and plays each finished line out
// as a run of character beats, or one error beat for a bad or long line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_rx_valid / o_rx_stall / i_rx_byte): one received byte per
//   beat. A carriage return is ignored, a line feed closes the line, any other
//   printable byte is stored. A non-printable byte, or a character that
//   arrives when the line already holds the limit, drops the line and yields
//   one error beat. Bytes are taken one per cycle while the job queue has room
//   and the store bank being filled is not still being read out.
//   Output channel (o_res_valid / i_res_stall): each beat carries result_kind,
//   line_char and last_of_run, held in an output register while stalled.
//   Order: an error job goes through the job queue, then the output register;
//   a line job goes through the queue, the store read and load steps, then
//   the output register. The readout engine takes each character through a
//   store read, a load and a hand-off, and reads the next one once the previous
//   is taken. The store has two banks, so the next line fills while one drains.
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data into the line limit; the
//   limit in force is the smaller of it and LINE_MAX.
//   Reset clears the line, the queue and the output; the limit returns to 64.
// ----------------------------------------------------------------------------
module text_line_assembler #(
    parameter int LINE_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic       o_result_kind,
    output logic [7:0] o_line_char,
    output logic       o_last_of_run
);

    // Configured line limit.
    logic [6:0] r_line_limit;

    // Front end to queue.
    logic          q_push;
    logic          q_full;
    tla_pkg::t_cmd q_in_cmd;

    // Queue to readout engine.
    logic          q_pop;
    logic          q_valid;
    tla_pkg::t_cmd q_out_cmd;

    // Store writes and bank release between the two halves.
    tla_pkg::t_mem_wr    mem_wr;
    tla_pkg::t_bank_free bank_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= tla_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_line_limit <= i_cfg_wr_data;
        end
    end

    tla_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_stall   (o_rx_stall),
        .i_rx_byte    (i_rx_byte),
        .i_line_limit (r_line_limit),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd),
        .o_mem_wr     (mem_wr),
        .i_bank_free  (bank_free)
    );

    tla_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    tla_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mem_wr      (mem_wr),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .o_bank_free   (bank_free),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_result_kind (o_result_kind),
        .o_line_char   (o_line_char),
        .o_last_of_run (o_last_of_run)
    );

endmodule
